/* sv/crwh_pkg.sv */
// Package for the closest ray-to-wall hit unit.
// Shared widths, angle constants, register indexes and the CORDIC arctangent steps.
// No dependencies.
package crwh_pkg;

    localparam int COORD_W  = 24;
    localparam int WIDX_W   = 6;
    localparam int OFF_W    = 18;
    localparam int WIU_W    = 7;
    localparam int MD_W     = 13;
    localparam int CFG_IX_W = 1;
    localparam int T_BITS   = 24;
    localparam int ANG_W    = 21;

    localparam int DEF_MAX_WALLS    = 64;
    localparam int DEF_FRAC_BITS    = 8;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam logic [MD_W-1:0] MD_RESET = 13'd3000;

    localparam logic [CFG_IX_W-1:0] REG_WALLS_IN_USE = 1'b0;
    localparam logic [CFG_IX_W-1:0] REG_MAX_DISTANCE = 1'b1;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 21'sd205887;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 21'sd102944;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 21'sd411775;
    localparam int                      CORDIC_K_Q30 = 652032874;

    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    // atan(2^-i) in Q16
    function automatic logic [17:0] atan_step(input logic [4:0] i);
        logic [17:0] v;
        begin
            case (i)
                5'd0:    v = 18'd51472;
                5'd1:    v = 18'd30386;
                5'd2:    v = 18'd16055;
                5'd3:    v = 18'd8150;
                5'd4:    v = 18'd4091;
                5'd5:    v = 18'd2047;
                default: v = (i <= 5'd16) ? (18'd1 << (5'd16 - i)) : 18'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* sv/crwh_if.sv */
// Channel interfaces for the closest ray-to-wall hit unit: item, result, config write.
// Depends on crwh_pkg.
interface crwh_item_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   mode;
    logic [crwh_pkg::WIDX_W-1:0]            wall_index;
    logic signed [crwh_pkg::COORD_W-1:0]    wall_start_x;
    logic signed [crwh_pkg::COORD_W-1:0]    wall_start_y;
    logic signed [crwh_pkg::COORD_W-1:0]    wall_end_x;
    logic signed [crwh_pkg::COORD_W-1:0]    wall_end_y;
    logic signed [crwh_pkg::COORD_W-1:0]    origin_x;
    logic signed [crwh_pkg::COORD_W-1:0]    origin_y;
    logic signed [crwh_pkg::COORD_W-1:0]    target_x;
    logic signed [crwh_pkg::COORD_W-1:0]    target_y;
    logic signed [crwh_pkg::OFF_W-1:0]      angle_offset;

    modport source (output valid, mode, wall_index, wall_start_x, wall_start_y, wall_end_x,
                    wall_end_y, origin_x, origin_y, target_x, target_y, angle_offset,
                    input ready);
    modport sink (input valid, mode, wall_index, wall_start_x, wall_start_y, wall_end_x,
                  wall_end_y, origin_x, origin_y, target_x, target_y, angle_offset,
                  output ready);
endinterface

interface crwh_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [crwh_pkg::COORD_W-1:0]    hit_x;
    logic signed [crwh_pkg::COORD_W-1:0]    hit_y;
    logic                                   wall_hit;

    modport source (output valid, hit_x, hit_y, wall_hit, input ready);
    modport sink (input valid, hit_x, hit_y, wall_hit, output ready);
endinterface

interface crwh_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [crwh_pkg::CFG_IX_W-1:0]      index;
    logic [crwh_pkg::MD_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/closest_ray_wall_hit_2d_unit.sv */
// Closest ray-to-wall hit unit, top level.
// Item, result and config channels; wall table, CORDIC direction unit and hit pipeline.
// Depends on crwh_pkg, crwh_if, crwh_wall_mem, crwh_cordic, crwh_hit_pipe.
//
// Usage: an item word with mode 0 writes one wall entry and gives no result. An item word
// with mode 1 casts a ray and gives one result word. A ray tests N walls, N the min of
// walls_in_use and MAX_WALLS; when N is 0 the wall scan is skipped. The CORDIC runs one
// step a cycle, the wall table is read one entry a cycle into the hit pipeline, whose
// divider is T_BITS deep. One ray is in flight at a time. Config words (walls_in_use,
// max_distance) are taken every cycle and must be written only while idle. Reset sets
// walls_in_use to 0 and max_distance to 3000; the wall table is undefined until written.
// The result sits in an output register: new items are accepted while it waits; a
// finished ray holds until the register is free.
module closest_ray_wall_hit_2d_unit #(
    parameter int MAX_WALLS    = crwh_pkg::DEF_MAX_WALLS,
    parameter int FRAC_BITS    = crwh_pkg::DEF_FRAC_BITS,
    parameter int CORDIC_STEPS = crwh_pkg::DEF_CORDIC_STEPS
) (
    input  logic            clk,
    input  logic            rst_n,
    crwh_item_if.sink       item,
    crwh_result_if.source   result,
    crwh_cfg_if.sink        cfg
);

    localparam int CWD   = crwh_pkg::COORD_W;
    localparam int TB    = crwh_pkg::T_BITS;
    localparam int IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNT_W = ($clog2(MAX_WALLS + 1) > crwh_pkg::WIU_W) ?
                           $clog2(MAX_WALLS + 1) : crwh_pkg::WIU_W;
    localparam int DIR_W = FRAC_BITS + 16;
    localparam int HW    = DIR_W + TB + 3;

    localparam logic signed [HW-1:0] HALF_T  = HW'(1) << (TB - 1);
    localparam logic signed [HW-1:0] SAT_MAX = HW'(8388607);
    localparam logic signed [HW-1:0] SAT_MIN = -HW'(8388608);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIR   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // config registers
    logic [crwh_pkg::WIU_W-1:0] walls_in_use_reg;
    logic [crwh_pkg::MD_W-1:0]  max_distance_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walls_in_use_reg <= '0;
            max_distance_reg <= crwh_pkg::MD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                crwh_pkg::REG_WALLS_IN_USE: walls_in_use_reg <= cfg.data[crwh_pkg::WIU_W-1:0];
                crwh_pkg::REG_MAX_DISTANCE: max_distance_reg <= cfg.data;
                default:                    ;
            endcase
        end
    end

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic signed [CWD-1:0] ox_reg, oy_reg;
    logic signed [HW-1:0]  prod_x_reg, prod_y_reg;
    logic                  res_valid_reg;
    logic signed [CWD-1:0] res_x_reg, res_y_reg;
    logic                  res_hit_reg;

    logic [CNT_W-1:0]      n_walls, wiu_ext, widx_ext;
    logic                  accept, ray_go, wr_go, scan_last, out_free;
    crwh_pkg::ctl_t        issue_ctl, rd_ctl_reg;

    assign wiu_ext   = CNT_W'(walls_in_use_reg);
    assign n_walls   = (wiu_ext < CNT_W'(MAX_WALLS)) ? wiu_ext : CNT_W'(MAX_WALLS);
    assign widx_ext  = CNT_W'(item.wall_index);
    assign item.ready = (state_reg == S_IDLE);
    assign accept    = item.valid && item.ready;
    assign ray_go    = accept && item.mode;
    assign wr_go     = accept && !item.mode && (widx_ext < CNT_W'(MAX_WALLS));
    assign scan_last = (k_reg == n_walls - 1'b1);
    assign out_free  = !res_valid_reg || result.ready;

    // direction unit
    logic                    dir_done;
    logic signed [DIR_W-1:0] dir_x, dir_y;

    crwh_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS),
        .DIR_W        (DIR_W)
    ) u_cordic (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (ray_go),
        .dx           ($signed({item.target_x[CWD-1], item.target_x})
                       - $signed({item.origin_x[CWD-1], item.origin_x})),
        .dy           ($signed({item.target_y[CWD-1], item.target_y})
                       - $signed({item.origin_y[CWD-1], item.origin_y})),
        .offset       (item.angle_offset),
        .max_distance (max_distance_reg),
        .done         (dir_done),
        .dir_x        (dir_x),
        .dir_y        (dir_y)
    );

    // wall table
    logic [2*CWD-1:0] rd_start, rd_end;

    crwh_wall_mem #(
        .MAX_WALLS (MAX_WALLS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_go),
        .wr_addr  (widx_ext[IDX_W-1:0]),
        .wr_start ({item.wall_start_y, item.wall_start_x}),
        .wr_end   ({item.wall_end_y, item.wall_end_x}),
        .rd_en    (issue_ctl.valid),
        .rd_addr  (k_reg[IDX_W-1:0]),
        .rd_start (rd_start),
        .rd_end   (rd_end)
    );

    always_comb
    begin
        issue_ctl.valid = (state_reg == S_SCAN);
        issue_ctl.last  = scan_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_ctl_reg <= '0;
        else
            rd_ctl_reg <= issue_ctl;
    end

    // hit pipeline
    logic [TB:0] best;
    logic        hit, pipe_done;

    crwh_hit_pipe #(
        .DIR_W (DIR_W)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (state_reg == S_DIR),
        .ctl_in     (rd_ctl_reg),
        .wall_start (rd_start),
        .wall_end   (rd_end),
        .ox         (ox_reg),
        .oy         (oy_reg),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .best       (best),
        .hit        (hit),
        .done       (pipe_done)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ray_go)
                    state_next = S_DIR;
            end
            S_DIR:
            begin
                k_next = '0;
                if (dir_done)
                    state_next = (n_walls == '0) ? S_MUL : S_SCAN;
            end
            S_SCAN:
            begin
                k_next = k_reg + 1'b1;
                if (scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (pipe_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ray_go)
        begin
            ox_reg <= item.origin_x;
            oy_reg <= item.origin_y;
        end
        if (state_reg == S_MUL)
        begin
            prod_x_reg <= dir_x * $signed({1'b0, best});
            prod_y_reg <= dir_y * $signed({1'b0, best});
        end
    end

    // hit point: origin + round(dir * t); t is full length on a miss
    logic signed [HW-1:0] sum_x, sum_y;

    assign sum_x = ((prod_x_reg + HALF_T) >>> TB) + ox_reg;
    assign sum_y = ((prod_y_reg + HALF_T) >>> TB) + oy_reg;

    function automatic logic signed [CWD-1:0] sat(input logic signed [HW-1:0] v);
        begin
            if (v > SAT_MAX)
                return SAT_MAX[CWD-1:0];
            else if (v < SAT_MIN)
                return SAT_MIN[CWD-1:0];
            else
                return v[CWD-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            res_x_reg   <= sat(sum_x);
            res_y_reg   <= sat(sum_y);
            res_hit_reg <= hit;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.hit_x    = res_x_reg;
    assign result.hit_y    = res_y_reg;
    assign result.wall_hit = res_hit_reg;

endmodule

/* sv/crwh_wall_mem.sv */
// Wall table: start and end point memories, one write and one registered read port.
// Depends on crwh_pkg.
module crwh_wall_mem #(
    parameter int MAX_WALLS = crwh_pkg::DEF_MAX_WALLS,
    parameter int IDX_W     = 6
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [IDX_W-1:0]                    wr_addr,
    input  logic [2*crwh_pkg::COORD_W-1:0]      wr_start,
    input  logic [2*crwh_pkg::COORD_W-1:0]      wr_end,
    input  logic                                rd_en,
    input  logic [IDX_W-1:0]                    rd_addr,
    output logic [2*crwh_pkg::COORD_W-1:0]      rd_start,
    output logic [2*crwh_pkg::COORD_W-1:0]      rd_end
);

    logic [2*crwh_pkg::COORD_W-1:0] wall_start_store [0:MAX_WALLS-1];
    logic [2*crwh_pkg::COORD_W-1:0] wall_end_store   [0:MAX_WALLS-1];
    logic [2*crwh_pkg::COORD_W-1:0] rd_start_reg;
    logic [2*crwh_pkg::COORD_W-1:0] rd_end_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wall_start_store[wr_addr] <= wr_start;
            wall_end_store[wr_addr]   <= wr_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_start_reg <= wall_start_store[rd_addr];
            rd_end_reg   <= wall_end_store[rd_addr];
        end
    end

    assign rd_start = rd_start_reg;
    assign rd_end   = rd_end_reg;

endmodule

/* sv/crwh_cordic.sv */
// Ray direction: vectoring CORDIC for the aim angle, rotation CORDIC for the unit
// vector, then scaling by the ray length. One CORDIC step per cycle. Depends on crwh_pkg.
module crwh_cordic #(
    parameter int CORDIC_STEPS = crwh_pkg::DEF_CORDIC_STEPS,
    parameter int FRAC_BITS    = crwh_pkg::DEF_FRAC_BITS,
    parameter int DIR_W        = crwh_pkg::DEF_FRAC_BITS + 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [crwh_pkg::COORD_W:0]   dx,
    input  logic signed [crwh_pkg::COORD_W:0]   dy,
    input  logic signed [crwh_pkg::OFF_W-1:0]   offset,
    input  logic [crwh_pkg::MD_W-1:0]           max_distance,
    output logic                                done,
    output logic signed [DIR_W-1:0]             dir_x,
    output logic signed [DIR_W-1:0]             dir_y
);

    localparam int XW = 44;
    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam int RS = 30 - FRAC_BITS;
    localparam int PW = 47;
    localparam int AW = crwh_pkg::ANG_W;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_VEC  = 3'd1;
    localparam logic [2:0] C_PREP = 3'd2;
    localparam logic [2:0] C_ROT  = 3'd3;
    localparam logic [2:0] C_MUL  = 3'd4;
    localparam logic [2:0] C_RND  = 3'd5;

    localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (RS - 1);

    logic [2:0]              state_reg;
    logic [SW-1:0]           step_reg;
    logic signed [XW-1:0]    x_reg, y_reg;
    logic signed [AW-1:0]    z_reg, base_reg;
    logic signed [crwh_pkg::OFF_W-1:0] off_reg;
    logic                    flip_reg;
    logic signed [PW-1:0]    prod_x_reg, prod_y_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg;
    logic                    done_reg;

    logic signed [XW-1:0]    xs, ys, x_next, y_next, dxe, dye, cx, cy;
    logic signed [AW-1:0]    at, z_next, a0, a1, a2;
    logic                    s_pos, flip_next, last_step;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = $signed({3'b000, crwh_pkg::atan_step(5'(step_reg))});
    assign last_step = (step_reg == SW'(CORDIC_STEPS - 1));
    assign dxe = {{(XW - 41){dx[crwh_pkg::COORD_W]}}, dx, 16'h0000};
    assign dye = {{(XW - 41){dy[crwh_pkg::COORD_W]}}, dy, 16'h0000};
    assign cx = flip_reg ? -x_reg : x_reg;
    assign cy = flip_reg ? -y_reg : y_reg;

    always_comb
    begin
        s_pos = (state_reg == C_VEC) ? !(y_reg > 0) : !z_reg[AW-1];
        if (s_pos)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    // angle wrap and half-plane fold
    always_comb
    begin
        a0 = base_reg + z_reg + AW'(off_reg);
        if (a0 > crwh_pkg::ANG_PI)
            a1 = a0 - crwh_pkg::ANG_TWO_PI;
        else if (a0 < -crwh_pkg::ANG_PI)
            a1 = a0 + crwh_pkg::ANG_TWO_PI;
        else
            a1 = a0;
        flip_next = 1'b0;
        a2 = a1;
        if (a1 > crwh_pkg::ANG_HALF_PI)
        begin
            a2 = a1 - crwh_pkg::ANG_PI;
            flip_next = 1'b1;
        end
        else if (a1 < -crwh_pkg::ANG_HALF_PI)
        begin
            a2 = a1 + crwh_pkg::ANG_PI;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        if (dx == '0 && dy == '0)
                            state_reg <= C_PREP;
                        else
                            state_reg <= C_VEC;
                    end
                end
                C_VEC:
                begin
                    if (last_step)
                        state_reg <= C_PREP;
                end
                C_PREP:
                begin
                    state_reg <= C_ROT;
                end
                C_ROT:
                begin
                    if (last_step)
                        state_reg <= C_MUL;
                end
                C_MUL:
                begin
                    state_reg <= C_RND;
                end
                C_RND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                step_reg <= '0;
                z_reg    <= '0;
                off_reg  <= offset;
                if (dx < 0)
                begin
                    x_reg    <= -dxe;
                    y_reg    <= -dye;
                    base_reg <= (dy >= 0) ? crwh_pkg::ANG_PI : -crwh_pkg::ANG_PI;
                end
                else
                begin
                    x_reg    <= dxe;
                    y_reg    <= dye;
                    base_reg <= '0;
                end
            end
            C_VEC, C_ROT:
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                z_reg    <= z_next;
                step_reg <= step_reg + 1'b1;
            end
            C_PREP:
            begin
                x_reg    <= XW'(crwh_pkg::CORDIC_K_Q30);
                y_reg    <= '0;
                z_reg    <= a2;
                flip_reg <= flip_next;
                step_reg <= '0;
            end
            C_MUL:
            begin
                prod_x_reg <= $signed(cx[32:0]) * $signed({1'b0, max_distance});
                prod_y_reg <= $signed(cy[32:0]) * $signed({1'b0, max_distance});
            end
            C_RND:
            begin
                dir_x_reg <= DIR_W'((prod_x_reg + RND_HALF) >>> RS);
                dir_y_reg <= DIR_W'((prod_y_reg + RND_HALF) >>> RS);
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign dir_x = dir_x_reg;
    assign dir_y = dir_y_reg;

endmodule

/* sv/crwh_hit_pipe.sv */
// Per-wall intersection test, one wall a cycle: determinant and numerators, sign fold,
// 24-stage restoring divider for the ray parameter, nearest-hit tracking. Depends on crwh_pkg.
module crwh_hit_pipe #(
    parameter int DIR_W = crwh_pkg::DEF_FRAC_BITS + 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  crwh_pkg::ctl_t                      ctl_in,
    input  logic [2*crwh_pkg::COORD_W-1:0]      wall_start,
    input  logic [2*crwh_pkg::COORD_W-1:0]      wall_end,
    input  logic signed [crwh_pkg::COORD_W-1:0] ox,
    input  logic signed [crwh_pkg::COORD_W-1:0] oy,
    input  logic signed [DIR_W-1:0]             dir_x,
    input  logic signed [DIR_W-1:0]             dir_y,
    output logic [crwh_pkg::T_BITS:0]           best,
    output logic                                hit,
    output logic                                done
);

    localparam int CWD = crwh_pkg::COORD_W;
    localparam int TB  = crwh_pkg::T_BITS;
    localparam int PW  = ((DIR_W > CWD + 1) ? DIR_W : CWD + 1) + CWD + 1;
    localparam int CW  = PW + 2;

    logic signed [CWD-1:0] sx, sy, ex, ey;
    assign sx = wall_start[CWD-1:0];
    assign sy = wall_start[2*CWD-1:CWD];
    assign ex = wall_end[CWD-1:0];
    assign ey = wall_end[2*CWD-1:CWD];

    // differences
    logic signed [CWD:0] wx_reg, wy_reg, px_reg, py_reg;
    crwh_pkg::ctl_t      c1_reg, c2_reg, c3_reg;

    always_ff @(posedge clk)
    begin
        wx_reg <= $signed({ex[CWD-1], ex}) - $signed({sx[CWD-1], sx});
        wy_reg <= $signed({ey[CWD-1], ey}) - $signed({sy[CWD-1], sy});
        px_reg <= $signed({sx[CWD-1], sx}) - $signed({ox[CWD-1], ox});
        py_reg <= $signed({sy[CWD-1], sy}) - $signed({oy[CWD-1], oy});
    end

    // products
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;

    always_ff @(posedge clk)
    begin
        pa_reg <= dir_x * wy_reg;
        pb_reg <= dir_y * wx_reg;
        pc_reg <= px_reg * wy_reg;
        pd_reg <= py_reg * wx_reg;
        pe_reg <= px_reg * dir_y;
        pf_reg <= py_reg * dir_x;
    end

    // determinant and numerators
    logic signed [CW-1:0] det_reg, rn_reg, wn_reg;

    always_ff @(posedge clk)
    begin
        det_reg <= pa_reg - pb_reg;
        rn_reg  <= pc_reg - pd_reg;
        wn_reg  <= pe_reg - pf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else
        begin
            c1_reg <= ctl_in;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    // sign fold and range checks
    logic signed [CW-1:0] detn, rnn, wnn;
    logic                 cand;

    always_comb
    begin
        if (det_reg[CW-1])
        begin
            detn = -det_reg;
            rnn  = -rn_reg;
            wnn  = -wn_reg;
        end
        else
        begin
            detn = det_reg;
            rnn  = rn_reg;
            wnn  = wn_reg;
        end
        cand = (det_reg != '0) && (rnn > 0) && (rnn < detn) && !wnn[CW-1] && (wnn <= detn);
    end

    // divider stages
    logic [CW-1:0]      dv_r    [0:TB-1];
    logic [CW-1:0]      dv_d    [0:TB-1];
    logic [TB-1:0]      dv_q    [0:TB];
    crwh_pkg::ctl_t     dv_ctl  [0:TB];
    logic               dv_cand [0:TB];

    always_ff @(posedge clk)
    begin
        dv_r[0] <= rnn;
        dv_d[0] <= detn;
        dv_q[0] <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_ctl[0]  <= '0;
            dv_cand[0] <= 1'b0;
        end
        else
        begin
            dv_ctl[0]  <= c3_reg;
            dv_cand[0] <= cand && c3_reg.valid;
        end
    end

    for (genvar b = 0; b < TB; b++)
    begin : g_div
        logic [CW-1:0] r2;
        logic          ge;

        assign r2 = dv_r[b] << 1;
        assign ge = (r2 >= dv_d[b]);

        always_ff @(posedge clk)
        begin
            dv_q[b+1] <= {dv_q[b][TB-2:0], ge};
        end

        if (b < TB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                dv_r[b+1] <= ge ? (r2 - dv_d[b]) : r2;
                dv_d[b+1] <= dv_d[b];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_ctl[b+1]  <= '0;
                dv_cand[b+1] <= 1'b0;
            end
            else
            begin
                dv_ctl[b+1]  <= dv_ctl[b];
                dv_cand[b+1] <= dv_cand[b];
            end
        end
    end

    // nearest hit; strict compare keeps the lower index on a tie
    logic [TB:0] best_reg;
    logic        hit_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= (TB+1)'(1) << TB;
            hit_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_ctl[TB].valid && dv_ctl[TB].last;
            if (clear)
            begin
                best_reg <= (TB+1)'(1) << TB;
                hit_reg  <= 1'b0;
            end
            else if (dv_ctl[TB].valid && dv_cand[TB] && ({1'b0, dv_q[TB]} < best_reg))
            begin
                best_reg <= {1'b0, dv_q[TB]};
                hit_reg  <= 1'b1;
            end
        end
    end

    assign best = best_reg;
    assign hit  = hit_reg;
    assign done = done_reg;

endmodule
